[sv/pra_pkg.sv]
package pra_pkg;

    // Field widths of the stream payloads
    localparam int KIND_W   = 2;
    localparam int OWNER_W  = 8;
    localparam int SIZE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int START_W  = 5;
    localparam int COUNT_W  = 6;
    localparam int FRAG_W   = 6;

    // Register map: one register, index taken from paddr[2]
    localparam int   APB_ADDR_W   = 3;
    localparam logic REG_FIT_MODE = 1'b0;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FRAG   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_OWNER = 3'd1;
    localparam logic [STATUS_W-1:0] ST_PRESENT   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_MEM    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ABSENT    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_ZERO_SIZE = 3'd5;

    // Controller to datapath
    typedef struct packed {
        logic latch;    // take the input transfer
        logic scan;     // issue page reads
        logic wr_init;  // point the write pass at the chosen hole
        logic wr_step;  // write one page of the run
        logic load;     // load the result register
    } pra_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic imm;        // result known without a scan
        logic proc_last;  // last page is being processed
        logic alloc_go;   // allocation found a hole
        logic wr_last;    // this write step ends the run
        logic out_free;   // result register can take a new result
    } pra_stat_t;

endpackage

[sv/page_run_allocator.sv]
// Channel   Direction  Handshake                Payload
// s_        in         s_tvalid / s_tready      s_tuser kind, s_tdata owner_id, size_kb
// m_        out        m_tvalid / m_tready      m_tdata status, start_page, page_count,
//                                                fragments
// apb       in/out     psel, penable, pready    fit_mode at byte address 0
//
// Allocate, free and fragment requests scan the page map one page a cycle
// through the memory read port; a successful allocation then writes
// ceil(size_kb / PAGE_KB) pages of its run. Requests rejected on owner,
// size or kind alone give a result without a scan. The next request is
// taken in the cycle after the result is loaded.
// A stalled result sits in the output register; a second result waits in
// the controller until it is taken. Reset empties the map at once.
module page_run_allocator
    import pra_pkg::*;
#(
    parameter int PAGE_COUNT = 32,
    parameter int PAGE_KB    = 4,
    parameter int OWNER_BITS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // request stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,   // [7:0] owner_id, [15:8] size_kb
    input  logic [1:0]            s_tuser,   // [1:0] kind
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,   // [2:0] status, [7:3] start_page,
                                             // [13:8] page_count, [19:14] fragments
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic                fit_mode_reg;
    logic                cfg_wr;
    pra_cmd_t            cmd;
    pra_stat_t           stat;
    logic [STATUS_W-1:0] res_status;
    logic [START_W-1:0]  res_start;
    logic [COUNT_W-1:0]  res_count;
    logic [FRAG_W-1:0]   res_frags;

    // Configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fit_mode_reg <= 1'b0;
        end else if (cfg_wr && (paddr[2] == REG_FIT_MODE)) begin
            fit_mode_reg <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == REG_FIT_MODE) ? {31'b0, fit_mode_reg} : 32'b0;

    pra_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pra_datapath #(
        .PAGE_COUNT (PAGE_COUNT),
        .PAGE_KB    (PAGE_KB),
        .OWNER_BITS (OWNER_BITS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fit_mode   (fit_mode_reg),
        .in_kind    (s_tuser),
        .in_owner   (s_tdata[7:0]),
        .in_size    (s_tdata[15:8]),
        .cmd        (cmd),
        .stat       (stat),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (res_status),
        .out_start  (res_start),
        .out_count  (res_count),
        .out_frags  (res_frags)
    );

    // Result packing, zero padded to whole bytes
    assign m_tdata = {4'b0, res_frags, res_count, res_start, res_status};

endmodule

[sv/pra_ctrl.sv]
module pra_ctrl
    import pra_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  pra_stat_t stat,
    output pra_cmd_t  cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_START  = 6'b000010,
        S_SCAN   = 6'b000100,
        S_CHECK  = 6'b001000,
        S_WRITE  = 6'b010000,
        S_RESULT = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Sequencing of one request
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.latch  = 1'b1;
                    state_next = S_START;
                end
            end
            S_START: begin
                state_next = stat.imm ? S_RESULT : S_SCAN;
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
                if (stat.proc_last) begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (stat.alloc_go) begin
                    cmd.wr_init = 1'b1;
                    state_next  = S_WRITE;
                end else begin
                    state_next = S_RESULT;
                end
            end
            S_WRITE: begin
                cmd.wr_step = 1'b1;
                if (stat.wr_last) begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT: begin
                if (stat.out_free) begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule

[sv/pra_datapath.sv]
module pra_datapath
    import pra_pkg::*;
#(
    parameter int PAGE_COUNT = 32,
    parameter int PAGE_KB    = 4,
    parameter int OWNER_BITS = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                fit_mode,
    input  logic [KIND_W-1:0]   in_kind,
    input  logic [OWNER_W-1:0]  in_owner,
    input  logic [SIZE_W-1:0]   in_size,
    input  pra_cmd_t            cmd,
    output pra_stat_t           stat,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STATUS_W-1:0] out_status,
    output logic [START_W-1:0]  out_start,
    output logic [COUNT_W-1:0]  out_count,
    output logic [FRAG_W-1:0]   out_frags
);

    localparam int IW   = $clog2(PAGE_COUNT);
    localparam int CW   = $clog2(PAGE_COUNT + 1);
    localparam int KBW  = $clog2(PAGE_COUNT * PAGE_KB + 1);
    localparam int FW   = $clog2(PAGE_KB + 1);
    localparam int CMPW = (KBW > SIZE_W) ? KBW : SIZE_W;

    localparam logic [IW-1:0]     LAST_PAGE    = IW'(PAGE_COUNT - 1);
    localparam logic [KBW-1:0]    PAGE_KB_RUN  = KBW'(PAGE_KB);
    localparam logic [FW-1:0]     PAGE_KB_FILL = FW'(PAGE_KB);
    localparam logic [SIZE_W-1:0] PAGE_KB_SIZE = SIZE_W'(PAGE_KB);

    // Page map memory, valid bits stand for the cleared state after reset
    logic [OWNER_BITS-1:0] owner_mem [PAGE_COUNT];
    logic [FW-1:0]         fill_mem  [PAGE_COUNT];
    logic [PAGE_COUNT-1:0] page_vld_reg;

    // Latched request
    logic [KIND_W-1:0]     kind_reg, kind_next;
    logic [OWNER_BITS-1:0] who_reg, who_next;
    logic [SIZE_W-1:0]     size_reg, size_next;

    // Scan address and read stage
    logic [IW-1:0]         addr_reg, addr_next;
    logic                  issue_done_reg, issue_done_next;
    logic                  rd_en;
    logic                  rd_vld_reg;
    logic [IW-1:0]         rd_idx_reg;
    logic [OWNER_BITS-1:0] rd_owner_reg;
    logic [FW-1:0]         rd_fill_reg;
    logic                  rd_page_vld_reg;

    // Scan accumulators
    logic                  present_reg, present_next;
    logic [KBW-1:0]        run_kb_reg, run_kb_next;
    logic [IW-1:0]         run_start_reg, run_start_next;
    logic                  found_reg, found_next;
    logic [KBW-1:0]        best_kb_reg, best_kb_next;
    logic [IW-1:0]         best_start_reg, best_start_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [CW-1:0]         frag_run_reg, frag_run_next;
    logic [CW-1:0]         frag_reg, frag_next;
    logic [SIZE_W-1:0]     rem_reg, rem_next;

    // Page write port
    logic                  wr_en;
    logic [IW-1:0]         wr_addr;
    logic [OWNER_BITS-1:0] wr_owner;
    logic [FW-1:0]         wr_fill;

    // Per-page terms
    logic [OWNER_BITS-1:0] owner_rd;
    logic [FW-1:0]         fill_rd;
    logic                  page_free;
    logic [KBW-1:0]        ext_kb;
    logic [IW-1:0]         ext_start;
    logic                  cand_ok;
    logic [KBW-1:0]        cand_kb;
    logic [IW-1:0]         cand_start;
    logic                  cand_fits;
    logic                  cand_better;
    logic [CW-1:0]         frag_run_inc;
    logic                  wr_last;
    logic                  who_zero;

    // Result register
    logic                  out_valid_reg;
    logic [STATUS_W-1:0]   out_status_reg;
    logic [START_W-1:0]    out_start_reg;
    logic [COUNT_W-1:0]    out_count_reg;
    logic [FRAG_W-1:0]     out_frags_reg;
    logic [STATUS_W-1:0]   res_status;
    logic [START_W-1:0]    res_start;
    logic [COUNT_W-1:0]    res_count;
    logic [FRAG_W-1:0]     res_frags;

    // Page just read: unwritten pages read as free and empty
    always_comb begin
        owner_rd     = rd_page_vld_reg ? rd_owner_reg : '0;
        fill_rd      = rd_page_vld_reg ? rd_fill_reg : '0;
        page_free    = (owner_rd == '0);
        ext_kb       = run_kb_reg + PAGE_KB_RUN;
        ext_start    = (run_kb_reg == '0) ? rd_idx_reg : run_start_reg;
        frag_run_inc = frag_run_reg + CW'(fill_rd < PAGE_KB_FILL);
        wr_last      = (rem_reg <= PAGE_KB_SIZE);
        who_zero     = (who_reg == '0);
    end

    // Hole closing on this page: an occupied page ends the open run,
    // a free last page ends the run it extends
    always_comb begin
        if (page_free) begin
            cand_ok    = (rd_idx_reg == LAST_PAGE);
            cand_kb    = ext_kb;
            cand_start = ext_start;
        end else begin
            cand_ok    = (run_kb_reg != '0);
            cand_kb    = run_kb_reg;
            cand_start = run_start_reg;
        end
        cand_fits   = cand_ok && (CMPW'(cand_kb) >= CMPW'(size_reg));
        cand_better = !found_reg ||
                      (fit_mode ? (cand_kb > best_kb_reg) : (cand_kb < best_kb_reg));
    end

    // Next-state logic of the datapath
    always_comb begin
        kind_next       = kind_reg;
        who_next        = who_reg;
        size_next       = size_reg;
        addr_next       = addr_reg;
        issue_done_next = issue_done_reg;
        present_next    = present_reg;
        run_kb_next     = run_kb_reg;
        run_start_next  = run_start_reg;
        found_next      = found_reg;
        best_kb_next    = best_kb_reg;
        best_start_next = best_start_reg;
        cnt_next        = cnt_reg;
        frag_run_next   = frag_run_reg;
        frag_next       = frag_reg;
        rem_next        = rem_reg;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = rd_idx_reg;
        wr_owner        = '0;
        wr_fill         = '0;

        if (cmd.latch) begin
            kind_next       = in_kind;
            who_next        = OWNER_BITS'(in_owner);
            size_next       = in_size;
            addr_next       = '0;
            issue_done_next = 1'b0;
            present_next    = 1'b0;
            run_kb_next     = '0;
            run_start_next  = '0;
            found_next      = 1'b0;
            best_kb_next    = '0;
            best_start_next = '0;
            cnt_next        = '0;
            frag_run_next   = '0;
            frag_next       = '0;
        end

        // Issue one page read a cycle
        if (cmd.scan && !issue_done_reg) begin
            rd_en = 1'b1;
            if (addr_reg == LAST_PAGE) begin
                issue_done_next = 1'b1;
            end else begin
                addr_next = addr_reg + 1'b1;
            end
        end

        // Process the page read in the previous cycle
        if (rd_vld_reg) begin
            if (owner_rd == who_reg) begin
                present_next = 1'b1;
            end
            run_kb_next    = page_free ? ext_kb : '0;
            run_start_next = ext_start;
            if (cand_fits && cand_better) begin
                found_next      = 1'b1;
                best_kb_next    = cand_kb;
                best_start_next = cand_start;
            end
            frag_run_next = frag_run_inc;
            if (!page_free) begin
                frag_next = frag_run_inc;
            end
            // Release a page of the owner being freed
            if ((kind_reg == KIND_FREE) && (owner_rd == who_reg)) begin
                wr_en    = 1'b1;
                wr_addr  = rd_idx_reg;
                cnt_next = cnt_reg + 1'b1;
            end
        end

        if (cmd.wr_init) begin
            addr_next = best_start_reg;
            rem_next  = size_reg;
        end

        // Claim one page of the run; the last holds the remainder
        if (cmd.wr_step) begin
            wr_en     = 1'b1;
            wr_addr   = addr_reg;
            wr_owner  = who_reg;
            wr_fill   = wr_last ? FW'(rem_reg) : PAGE_KB_FILL;
            addr_next = addr_reg + 1'b1;
            rem_next  = rem_reg - PAGE_KB_SIZE;
            cnt_next  = cnt_reg + 1'b1;
        end
    end

    // Page memory write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            owner_mem[wr_addr] <= wr_owner;
            fill_mem[wr_addr]  <= wr_fill;
        end
        if (rd_en) begin
            rd_owner_reg    <= owner_mem[addr_reg];
            rd_fill_reg     <= fill_mem[addr_reg];
            rd_page_vld_reg <= page_vld_reg[addr_reg];
            rd_idx_reg      <= addr_reg;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_vld_reg   <= '0;
            rd_vld_reg     <= 1'b0;
            issue_done_reg <= 1'b1;
        end else begin
            if (wr_en) begin
                page_vld_reg[wr_addr] <= 1'b1;
            end
            rd_vld_reg     <= rd_en;
            issue_done_reg <= issue_done_next;
        end
    end

    // Payload and accumulator registers
    always_ff @(posedge aclk) begin
        kind_reg       <= kind_next;
        who_reg        <= who_next;
        size_reg       <= size_next;
        addr_reg       <= addr_next;
        present_reg    <= present_next;
        run_kb_reg     <= run_kb_next;
        run_start_reg  <= run_start_next;
        found_reg      <= found_next;
        best_kb_reg    <= best_kb_next;
        best_start_reg <= best_start_next;
        cnt_reg        <= cnt_next;
        frag_run_reg   <= frag_run_next;
        frag_reg       <= frag_next;
        rem_reg        <= rem_next;
    end

    // Result selection
    always_comb begin
        res_status = ST_OK;
        res_start  = '0;
        res_count  = '0;
        res_frags  = '0;
        priority if (kind_reg == KIND_ALLOC) begin
            priority if (who_zero) begin
                res_status = ST_BAD_OWNER;
            end else if (size_reg == '0) begin
                res_status = ST_ZERO_SIZE;
            end else if (present_reg) begin
                res_status = ST_PRESENT;
            end else if (!found_reg) begin
                res_status = ST_NO_MEM;
            end else begin
                res_start = START_W'(best_start_reg);
                res_count = COUNT_W'(cnt_reg);
            end
        end else if (kind_reg == KIND_FREE) begin
            priority if (who_zero) begin
                res_status = ST_BAD_OWNER;
            end else if (cnt_reg == '0) begin
                res_status = ST_ABSENT;
            end else begin
                res_count = COUNT_W'(cnt_reg);
            end
        end else if (kind_reg == KIND_FRAG) begin
            res_frags = FRAG_W'(frag_reg);
        end else begin
            res_status = ST_OK;
        end
    end

    // Result register, parts the request side from the result side
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            out_status_reg <= res_status;
            out_start_reg  <= res_start;
            out_count_reg  <= res_count;
            out_frags_reg  <= res_frags;
        end
    end

    // Status to the controller
    always_comb begin
        stat.imm       = (kind_reg == KIND_UNUSED) ||
                         (((kind_reg == KIND_ALLOC) || (kind_reg == KIND_FREE)) && who_zero) ||
                         ((kind_reg == KIND_ALLOC) && (size_reg == '0));
        stat.proc_last = rd_vld_reg && (rd_idx_reg == LAST_PAGE);
        stat.alloc_go  = (kind_reg == KIND_ALLOC) && !present_reg && found_reg;
        stat.wr_last   = wr_last;
        stat.out_free  = !out_valid_reg || out_ready;
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_start  = out_start_reg;
    assign out_count  = out_count_reg;
    assign out_frags  = out_frags_reg;

endmodule

[sv/pra_checker.sv]
module pra_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // A stalled result holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // One request at a time: no new transfer right after one is taken
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while another is in work");

    // Status is one of the defined codes
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2:0] != 3'd6) && (m_tdata[2:0] != 3'd7))
        else $error("undefined status code");

    // Every error result carries zero in the other fields
    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[2:0] != 3'd0) |-> (m_tdata[23:3] == 21'd0))
        else $error("error result with non-zero fields");

endmodule

bind page_run_allocator pra_checker u_pra_checker (.*);

[sim/tb_top.sv]
module tb_top;
    import pra_pkg::*;

    localparam int PAGES    = 32;
    localparam int PAGE_KB  = 4;
    localparam int WATCHDOG = 1000;
    localparam int SETTLE   = 80;

    // Expected content of one result transfer
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [START_W-1:0]  start_page;
        logic [COUNT_W-1:0]  page_count;
        logic [FRAG_W-1:0]   fragments;
    } alloc_result_t;

    // Shadow page map plus the queue of results still to arrive
    class alloc_scoreboard;
        logic [OWNER_W-1:0] owner_map [PAGES];
        logic [2:0]         fill_map [PAGES];
        bit                 worst_fit;
        alloc_result_t      expected_q [$];
        int unsigned        errors;

        function new();
            foreach (owner_map[i]) begin
                owner_map[i] = '0;
                fill_map[i]  = '0;
            end
            worst_fit = 1'b0;
            errors    = 0;
        endfunction

        // Work out the result of an accepted request and update the map
        function void note_request(logic [KIND_W-1:0] kind, logic [OWNER_W-1:0] owner,
                                   logic [SIZE_W-1:0] size_kb);
            alloc_result_t r;
            int need, rem, run_len, best_start, best_len, last_used, p, count;
            bit present;
            r = '0;
            case (kind)
                KIND_ALLOC: begin
                    present = 1'b0;
                    foreach (owner_map[i])
                        if (owner_map[i] == owner) present = 1'b1;
                    if (owner == 0) r.status = ST_BAD_OWNER;
                    else if (size_kb == 0) r.status = ST_ZERO_SIZE;
                    else if (present) r.status = ST_PRESENT;
                    else if (size_kb > PAGES * PAGE_KB) r.status = ST_NO_MEM;
                    else begin
                        need       = (size_kb + PAGE_KB - 1) / PAGE_KB;
                        rem        = size_kb % PAGE_KB;
                        best_start = -1;
                        best_len   = 0;
                        run_len    = 0;
                        // walk the free runs; strict compares keep the lowest on ties
                        for (p = 0; p <= PAGES; p++) begin
                            if (p < PAGES && owner_map[p] == 0) begin
                                run_len++;
                            end else begin
                                if (run_len >= need && (best_start < 0 ||
                                    (worst_fit ? run_len > best_len : run_len < best_len))) begin
                                    best_start = p - run_len;
                                    best_len   = run_len;
                                end
                                run_len = 0;
                            end
                        end
                        if (best_start < 0) begin
                            r.status = ST_NO_MEM;
                        end else begin
                            for (int k = 0; k < need; k++) begin
                                owner_map[best_start + k] = owner;
                                fill_map[best_start + k]  =
                                    (k == need - 1 && rem > 0) ? 3'(rem) : 3'(PAGE_KB);
                            end
                            r.status     = ST_OK;
                            r.start_page = START_W'(best_start);
                            r.page_count = COUNT_W'(need);
                        end
                    end
                end
                KIND_FREE: begin
                    if (owner == 0) begin
                        r.status = ST_BAD_OWNER;
                    end else begin
                        count = 0;
                        foreach (owner_map[i]) begin
                            if (owner_map[i] == owner) begin
                                owner_map[i] = '0;
                                fill_map[i]  = '0;
                                count++;
                            end
                        end
                        r.status     = (count == 0) ? ST_ABSENT : ST_OK;
                        r.page_count = COUNT_W'(count);
                    end
                end
                KIND_FRAG: begin
                    last_used = -1;
                    count     = 0;
                    foreach (owner_map[i])
                        if (owner_map[i] != 0) last_used = i;
                    for (p = 0; p <= last_used; p++)
                        if (fill_map[p] < PAGE_KB) count++;
                    r.status    = ST_OK;
                    r.fragments = FRAG_W'(count);
                end
                default: r = '0;
            endcase
            expected_q.push_back(r);
        endfunction

        task report_mismatch(string what, int got, int want);
            $display("%0t ERROR: %s got %0d expected %0d", $time, what, got, want);
            errors++;
        endtask

        // Compare one result transfer with the oldest expectation
        task check_result(logic [23:0] data);
            alloc_result_t want;
            if (expected_q.size() == 0) begin
                report_mismatch("result with nothing outstanding, m_tdata", data, 0);
                return;
            end
            want = expected_q.pop_front();
            if (data[2:0] != want.status)
                report_mismatch("status", data[2:0], want.status);
            if (data[7:3] != want.start_page)
                report_mismatch("start_page", data[7:3], want.start_page);
            if (data[13:8] != want.page_count)
                report_mismatch("page_count", data[13:8], want.page_count);
            if (data[19:14] != want.fragments)
                report_mismatch("fragments", data[19:14], want.fragments);
        endtask
    endclass

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata  = '0;   // [7:0] owner_id, [15:8] size_kb
    logic [1:0]            s_tuser  = '0;   // [1:0] kind
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [23:0]           m_tdata;         // [2:0] status, [7:3] start_page,
                                            // [13:8] page_count, [19:14] fragments
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [31:0]           pwdata   = '0;
    logic [31:0]           prdata;
    logic                  pready;

    alloc_scoreboard sb;
    bit              send_steady = 1'b0;
    bit              recv_steady = 1'b0;
    int unsigned     idle_cycles = 0;

    always #1 aclk = ~aclk;

    page_run_allocator i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Sample every transfer on both streams and the register port
    always @(posedge aclk) begin
        if (aresetn) begin
            if (psel && penable && pwrite && pready && paddr == {REG_FIT_MODE, 2'b00})
                sb.worst_fit = pwdata[0];
            if (s_tvalid && s_tready)
                sb.note_request(s_tuser, s_tdata[7:0], s_tdata[15:8]);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (psel && penable && pready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG) begin
                $display("%0t TIMEOUT: no transfer for %0d cycles", $time, idle_cycles);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Result side: random stall before each transfer, with steady stretches
    initial begin : result_sink
        int unsigned stall;
        forever begin
            if ($urandom_range(0, 31) == 0) recv_steady = !recv_steady;
            stall = recv_steady ? 0 : $urandom_range(0, 13);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // One request transfer, preceded by a random gap
    task automatic send_request(logic [KIND_W-1:0] kind, logic [OWNER_W-1:0] owner,
                                logic [SIZE_W-1:0] size_kb);
        int unsigned gap;
        if ($urandom_range(0, 31) == 0) send_steady = !send_steady;
        gap = send_steady ? 0 : $urandom_range(0, 13);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {size_kb, owner};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Hold off requests until every outstanding result has been taken
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Register write: setup cycle then access cycle; upper data bits are noise
    task automatic write_fit(bit mode);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_FIT_MODE, 2'b00};
        pwdata  <= {31'($urandom()), mode};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Random traffic over a small owner pool so the map fills and fragments
    task automatic run_random(int unsigned n);
        int unsigned pick;
        logic [KIND_W-1:0]  kind;
        logic [OWNER_W-1:0] owner;
        logic [SIZE_W-1:0]  size_kb;
        for (int unsigned i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 50)      kind = KIND_ALLOC;
            else if (pick < 80) kind = KIND_FREE;
            else if (pick < 96) kind = KIND_FRAG;
            else                kind = KIND_UNUSED;
            pick  = $urandom_range(0, 19);
            owner = (pick < 17) ? OWNER_W'($urandom_range(1, 12))
                                : OWNER_W'($urandom_range(0, 255));
            pick = $urandom_range(0, 19);
            if (pick < 11)      size_kb = SIZE_W'($urandom_range(1, 24));
            else if (pick < 16) size_kb = SIZE_W'($urandom_range(25, 64));
            else if (pick < 19) size_kb = SIZE_W'($urandom_range(65, 128));
            else                size_kb = SIZE_W'($urandom_range(0, 255));
            if ($urandom_range(0, 59) == 0) drain();
            send_request(kind, owner, size_kb);
        end
    endtask

    initial begin : stimulus
        sb = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // rejections and the empty map
        send_request(KIND_ALLOC, 8'd0,   8'd10);
        send_request(KIND_ALLOC, 8'd5,   8'd0);
        send_request(KIND_FRAG,  8'd0,   8'd0);
        send_request(KIND_FREE,  8'd0,   8'd0);
        send_request(KIND_FREE,  8'd7,   8'd0);
        // whole map to one owner, then full-map cases
        send_request(KIND_ALLOC, 8'd1,   8'd128);
        send_request(KIND_ALLOC, 8'd2,   8'd1);
        send_request(KIND_ALLOC, 8'd1,   8'd4);
        send_request(KIND_FRAG,  8'd0,   8'd0);
        send_request(KIND_FREE,  8'd1,   8'd0);
        // oversize requests
        send_request(KIND_ALLOC, 8'd3,   8'd129);
        send_request(KIND_ALLOC, 8'd255, 8'd255);
        // build two holes, then best fit picks the small one
        send_request(KIND_ALLOC, 8'd10,  8'd8);
        send_request(KIND_ALLOC, 8'd11,  8'd12);
        send_request(KIND_ALLOC, 8'd12,  8'd5);
        send_request(KIND_ALLOC, 8'd13,  8'd40);
        send_request(KIND_FREE,  8'd11,  8'd0);
        send_request(KIND_ALLOC, 8'd14,  8'd3);
        send_request(KIND_FRAG,  8'd0,   8'd0);
        send_request(KIND_UNUSED, 8'd255, 8'd255);
        // worst fit, ending on two equal holes
        drain();
        write_fit(1'b1);
        send_request(KIND_ALLOC, 8'd15,  8'd4);
        send_request(KIND_FREE,  8'd13,  8'd0);
        send_request(KIND_ALLOC, 8'd16,  8'd8);
        send_request(KIND_ALLOC, 8'd17,  8'd8);
        send_request(KIND_ALLOC, 8'd18,  8'd4);

        // random phases, alternating the fit setting
        for (int unsigned ph = 0; ph < 5; ph++) begin
            drain();
            write_fit(ph[0]);
            run_random(126);
        end

        drain();
        repeat (SETTLE) @(posedge aclk);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[page_run_allocator.f]
sv/pra_pkg.sv
sv/pra_ctrl.sv
sv/pra_datapath.sv
sv/page_run_allocator.sv
sv/pra_checker.sv
sim/tb_top.sv
